### rtl/core/weighted_least_used_link_selector_assert.svh
// assertion macros shared by the link selector rtl
// depends on nothing; clock and reset are passed by the user of each macro
`ifndef WEIGHTED_LEAST_USED_LINK_SELECTOR_ASSERT_SVH
`define WEIGHTED_LEAST_USED_LINK_SELECTOR_ASSERT_SVH
`ifndef SYNTHESIS
`define WLLS_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error("wlls assertion failed");
`define WLLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error("wlls implication failed");
`else
`define WLLS_ASSERT(lbl, clk, rst_n, prop)
`define WLLS_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`endif
`endif

### rtl/core/wlls_pkg.sv
// shared types and constants of the weighted least-used link selector
// no dependencies
package wlls_pkg;

	localparam int NUM_LINKS_DEF = 4;
	localparam int NUM_WEIGHTS   = 4;
	localparam int WEIGHT_W      = 8;
	localparam int COUNT_W       = 32;
	localparam int COST_W        = COUNT_W + WEIGHT_W;
	localparam int CFG_IDX_W     = 8;
	localparam int LINK_W        = 2;

	typedef enum logic [1:0] {
		MODE_CHOOSE = 2'd0,
		MODE_UP     = 2'd1,
		MODE_DOWN   = 2'd2,
		MODE_CLEAR  = 2'd3
	} mode_t;

	// control from the sequencer to the shared cost unit
	typedef struct packed {
		logic start;
		logic load;
		logic up;
	} cu_ctrl_t;

endpackage

### rtl/core/wlls_if.sv
// handshake channels of the link selector: request, result and config write
// depends on wlls_pkg
interface wlls_req_if;
	logic                 valid;
	logic                 ready;
	wlls_pkg::mode_t      mode;
	logic [1:0]           link_index;
	modport source (output valid, output mode, output link_index, input ready);
	modport sink (input valid, input mode, input link_index, output ready);
endinterface

interface wlls_rsp_if;
	logic       valid;
	logic       ready;
	logic [1:0] chosen_link;
	logic       no_link_up;
	modport source (output valid, output chosen_link, output no_link_up, input ready);
	modport sink (input valid, input chosen_link, input no_link_up, output ready);
endinterface

interface wlls_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [wlls_pkg::CFG_IDX_W-1:0] index;
	logic [wlls_pkg::WEIGHT_W-1:0]  data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

### rtl/core/wlls_cost_unit.sv
// shared multiply and compare unit: one link cost per cycle, keeps the running minimum
// depends on wlls_pkg
module wlls_cost_unit #(
	parameter int IDX_W = 2
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  wlls_pkg::cu_ctrl_t           ctrl,
	input  logic [wlls_pkg::COUNT_W-1:0] count,
	input  logic [wlls_pkg::WEIGHT_W-1:0] weight,
	input  logic [IDX_W-1:0]             idx,
	output logic [IDX_W-1:0]             best,
	output logic                         found
);
	import wlls_pkg::*;

	logic [COST_W-1:0] prod_s1;
	logic              vld_s1;
	logic              up_s1;
	logic [IDX_W-1:0]  idx_s1;
	logic [COST_W-1:0] least_q;
	logic [IDX_W-1:0]  best_q;
	logic              found_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= ctrl.load;
		end
	end

	always_ff @(posedge clk) begin
		prod_s1 <= COST_W'(count) * COST_W'(weight);
		up_s1   <= ctrl.up;
		idx_s1  <= idx;
	end

	// ties go to the later link, so equal cost replaces
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			found_q <= 1'b0;
			best_q  <= '0;
		end else if (ctrl.start) begin
			found_q <= 1'b0;
			best_q  <= '0;
		end else if (vld_s1 && up_s1 && (!found_q || prod_s1 <= least_q)) begin
			found_q <= 1'b1;
			best_q  <= idx_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s1 && up_s1 && (!found_q || prod_s1 <= least_q)) begin
			least_q <= prod_s1;
		end
	end

	assign best  = best_q;
	assign found = found_q;

endmodule

### rtl/core/weighted_least_used_link_selector.sv
// choose item: every link is scanned through the cost unit, the cost pipeline drains, then the
// result is registered once the result register is free, and the next item is taken back in idle;
// one cost multiply per link per cycle; link up, link down and clear items give no result
// reset: all counters zero, all links down, weights 1, no result pending
// depends on wlls_pkg, wlls_if, wlls_cost_unit and the assertion header
`include "weighted_least_used_link_selector_assert.svh"
module weighted_least_used_link_selector #(
	parameter int NUM_LINKS = wlls_pkg::NUM_LINKS_DEF
) (
	input  logic   clk,
	input  logic   arst_n,
	wlls_req_if.sink   req,
	wlls_rsp_if.source rsp,
	wlls_cfg_if.sink   cfg
);
	import wlls_pkg::*;

	localparam int IW = (NUM_LINKS > 1) ? $clog2(NUM_LINKS) : 1;

	typedef enum logic [1:0] {ST_IDLE, ST_SCAN, ST_DRAIN, ST_UPD} st_t;

	st_t                 state_q;
	logic [IW-1:0]       scan_q;
	logic [COUNT_W-1:0]  count_q [NUM_LINKS];
	logic [NUM_LINKS-1:0] link_up_q;
	logic [WEIGHT_W-1:0] weight_q [NUM_WEIGHTS];
	logic                out_vld_q;
	logic [LINK_W-1:0]   out_link_q;
	logic                out_none_q;

	logic                req_acc;
	logic                scan_last;
	logic                out_free;
	logic                upd_go;
	logic                ev_valid;
	logic                clr_all;
	logic [IW-1:0]       rd_idx;
	logic [IW+1:0]       scan_ext;
	logic [COUNT_W-1:0]  cnt_rd;
	logic [WEIGHT_W-1:0] scan_weight;
	logic [IW-1:0]       best;
	logic                found;
	logic [IW+1:0]       best_ext;
	cu_ctrl_t            cu_ctrl;

	assign req.ready = (state_q == ST_IDLE);
	assign cfg.ready = 1'b1;
	assign req_acc   = req.valid && req.ready;
	assign scan_last = (scan_q == IW'(NUM_LINKS - 1));
	assign out_free  = !out_vld_q || rsp.ready;
	assign upd_go    = (state_q == ST_UPD) && out_free;

	// link events beyond the link count are ignored entirely
	assign ev_valid = req_acc && (req.mode == MODE_UP || req.mode == MODE_DOWN)
		&& ({3'b000, req.link_index} < 5'(NUM_LINKS));
	assign clr_all  = ev_valid || (req_acc && req.mode == MODE_CLEAR);

	assign rd_idx   = (state_q == ST_UPD) ? best : scan_q;
	assign cnt_rd   = count_q[rd_idx];
	assign scan_ext = (IW + 2)'(scan_q);
	assign scan_weight = (scan_ext < (IW + 2)'(NUM_WEIGHTS)) ? weight_q[scan_ext[1:0]]
		: WEIGHT_W'(1);

	assign cu_ctrl.start = req_acc && req.mode == MODE_CHOOSE;
	assign cu_ctrl.load  = (state_q == ST_SCAN);
	assign cu_ctrl.up    = link_up_q[scan_q];

	wlls_cost_unit #(
		.IDX_W (IW)
	) u_cost (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (cu_ctrl),
		.count  (cnt_rd),
		.weight (scan_weight),
		.idx    (scan_q),
		.best   (best),
		.found  (found)
	);

	assign best_ext = (IW + 2)'(best);

	// sequencer and result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			scan_q     <= '0;
			out_vld_q  <= 1'b0;
			out_link_q <= '0;
			out_none_q <= 1'b0;
		end else begin
			if (upd_go) begin
				out_vld_q <= 1'b1;
			end else if (rsp.ready) begin
				out_vld_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (req_acc && req.mode == MODE_CHOOSE) begin
						scan_q  <= '0;
						state_q <= ST_SCAN;
					end
				end
				ST_SCAN: begin
					if (scan_last) begin
						state_q <= ST_DRAIN;
					end else begin
						scan_q <= scan_q + 1'b1;
					end
				end
				ST_DRAIN: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (out_free) begin
						out_link_q <= best_ext[1:0];
						out_none_q <= !found;
						state_q    <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// counters and link flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			link_up_q <= '0;
			for (int j = 0; j < NUM_LINKS; j++) begin
				count_q[j] <= '0;
			end
		end else begin
			if (clr_all) begin
				for (int j = 0; j < NUM_LINKS; j++) begin
					count_q[j] <= '0;
				end
			end else if (upd_go && cnt_rd != {COUNT_W{1'b1}}) begin
				count_q[best] <= cnt_rd + 1'b1;
			end
			if (ev_valid) begin
				for (int j = 0; j < NUM_LINKS; j++) begin
					if (5'(j) == {3'b000, req.link_index}) begin
						link_up_q[j] <= (req.mode == MODE_UP);
					end
				end
			end
		end
	end

	// weight registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < NUM_WEIGHTS; j++) begin
				weight_q[j] <= WEIGHT_W'(1);
			end
		end else if (cfg.valid && cfg.index < CFG_IDX_W'(NUM_WEIGHTS)) begin
			weight_q[cfg.index[1:0]] <= cfg.data;
		end
	end

	assign rsp.valid       = out_vld_q;
	assign rsp.chosen_link = out_link_q;
	assign rsp.no_link_up  = out_none_q;

	`WLLS_ASSERT_IMP(a_found_is_up, clk, arst_n, state_q == ST_UPD && found, link_up_q[best])
	`WLLS_ASSERT_IMP(a_none_all_down, clk, arst_n, state_q == ST_UPD && !found,
		link_up_q == '0 && best == '0)
	`WLLS_ASSERT_IMP(a_rsp_from_upd, clk, arst_n, $rose(out_vld_q), $past(state_q == ST_UPD))
	`WLLS_ASSERT_IMP(a_scan_in_range, clk, arst_n, state_q == ST_SCAN,
		scan_q <= IW'(NUM_LINKS - 1))

endmodule
